/* rtl/mtet_pkg.sv */
// ----------------------------------------------------------------------------
// mtet_pkg
// Shared widths, codes and types of the multi-timer expiry table.
// ----------------------------------------------------------------------------
`default_nettype none

package mtet_pkg;

   localparam int DEPTH_DEFAULT = 16;

   localparam int CMD_W     = 2;
   localparam int TIMEOUT_W = 24;
   localparam int ID_W      = 16;
   localparam int KIND_W    = 3;
   localparam int TIME_W    = 32;
   localparam int ORDER_W   = 32;

   localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SET    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CANCEL = 2'd2;

   localparam logic [KIND_W-1:0] K_SET_OK    = 3'd0;
   localparam logic [KIND_W-1:0] K_SET_FULL  = 3'd1;
   localparam logic [KIND_W-1:0] K_FIRED     = 3'd2;
   localparam logic [KIND_W-1:0] K_CANCELLED = 3'd3;
   localparam logic [KIND_W-1:0] K_NOT_FOUND = 3'd4;
   localparam logic [KIND_W-1:0] K_TICK_DONE = 3'd5;

   localparam logic [TIMEOUT_W-1:0] DELAY_MAX = {TIMEOUT_W{1'b1}};

   typedef struct packed {
      logic [TIME_W-1:0]    expiry;
      logic [TIMEOUT_W-1:0] period;
      logic [ID_W-1:0]      ident;
      logic                 rearm;
      logic [ORDER_W-1:0]   order;
   } entry_type;

endpackage

`default_nettype wire

/* rtl/mtet_if.sv */
// ----------------------------------------------------------------------------
// mtet_req_if / mtet_rsp_if
// Valid/ready channels carrying command items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface mtet_req_if;
   logic                            valid;
   logic                            ready;
   logic [mtet_pkg::CMD_W-1:0]      command;
   logic [mtet_pkg::TIMEOUT_W-1:0]  timeout_ms;
   logic                            repeat_on_fire;
   logic [mtet_pkg::ID_W-1:0]       cancel_id;

   modport source (output valid, output command, output timeout_ms,
                   output repeat_on_fire, output cancel_id, input ready);
   modport sink   (input valid, input command, input timeout_ms,
                   input repeat_on_fire, input cancel_id, output ready);
endinterface

interface mtet_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [mtet_pkg::KIND_W-1:0]     kind;
   logic [mtet_pkg::ID_W-1:0]       timer_ident;
   logic [mtet_pkg::TIMEOUT_W-1:0]  next_delay_ms;
   logic                            last;

   modport source (output valid, output kind, output timer_ident,
                   output next_delay_ms, output last, input ready);
   modport sink   (input valid, input kind, input timer_ident,
                   input next_delay_ms, input last, output ready);
endinterface

`default_nettype wire

/* rtl/multi_timer_expiry_table.sv */
// ----------------------------------------------------------------------------
// multi_timer_expiry_table
// Timer table with set, cancel and millisecond tick; entries held in one
// synchronous memory, scanned one entry per cycle.
// ----------------------------------------------------------------------------
//  channel    dir  handshake      payload
//  req_chan   in   valid/ready    command, timeout_ms, repeat_on_fire, cancel_id
//  rsp_chan   out  valid/ready    kind, timer_ident, next_delay_ms, last
//
//  Set and cancel make one pass over the entry memory (one read per cycle,
//  registered read data) between the accept and finish steps.
//  A tick makes one full pass per fired timer and one closing pass that
//  yields the next delay.
//  Synchronous reset clears state, time, counters, control flags and entry valid flags only.
//  The finish step waits while the result register is full and not taken.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_timer_expiry_table #(
   parameter int DEPTH = mtet_pkg::DEPTH_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   mtet_req_if.sink     req_chan,
   mtet_rsp_if.source   rsp_chan
);

   localparam int IDXW = $clog2(DEPTH);
   localparam int CW   = $clog2(DEPTH + 1);
   localparam logic [IDXW-1:0] LAST_IDX  = IDXW'(DEPTH - 1);
   localparam logic [CW-1:0]   DEPTH_CNT = CW'(DEPTH);

   localparam int TW = mtet_pkg::TIME_W;
   localparam int PW = mtet_pkg::TIMEOUT_W;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   // control
   logic [1:0]                        state_ff, state_in;
   logic [TW-1:0]                     now_ff, now_in;
   logic [mtet_pkg::ID_W-1:0]         id_ff, id_in;
   logic [mtet_pkg::ORDER_W-1:0]      order_ff, order_in;
   logic [DEPTH-1:0]                  vld_ff, vld_in;
   logic [CW-1:0]                     scan_cnt_ff, scan_cnt_in;
   logic                              chk_vld_ff, chk_vld_in;
   logic [IDXW-1:0]                   chk_idx_ff, chk_idx_in;
   logic                              found_ff, found_in;
   logic                              any_ff, any_in;
   logic [CW-1:0]                     fire_cnt_ff, fire_cnt_in;
   logic                              rsp_vld_ff, rsp_vld_in;

   // payload
   logic [mtet_pkg::CMD_W-1:0]        cmd_ff, cmd_in;
   logic [PW-1:0]                     timeout_ff, timeout_in;
   logic                              rearm_ff, rearm_in;
   logic [mtet_pkg::ID_W-1:0]         cid_ff, cid_in;
   logic [IDXW-1:0]                   best_idx_ff, best_idx_in;
   logic [TW-1:0]                     best_da_ff, best_da_in;
   logic [mtet_pkg::ORDER_W-1:0]      best_age_ff, best_age_in;
   logic [mtet_pkg::ID_W-1:0]         best_ident_ff, best_ident_in;
   logic [PW-1:0]                     best_period_ff, best_period_in;
   logic                              best_rearm_ff, best_rearm_in;
   logic [TW-1:0]                     min_d_ff, min_d_in;
   logic [mtet_pkg::KIND_W-1:0]       rsp_kind_ff, rsp_kind_in;
   logic [mtet_pkg::ID_W-1:0]         rsp_ident_ff, rsp_ident_in;
   logic [PW-1:0]                     rsp_delay_ff, rsp_delay_in;
   logic                              rsp_last_ff, rsp_last_in;

   // entry memory
   mtet_pkg::entry_type               mem [DEPTH];
   mtet_pkg::entry_type               rd_data_ff;
   logic [IDXW-1:0]                   rd_addr;
   logic                              mem_we;
   logic [IDXW-1:0]                   mem_wa;
   mtet_pkg::entry_type               mem_wd;

   // per-entry evaluation
   logic                              ent_v;
   logic [TW-1:0]                     da;
   logic [TW-1:0]                     late;
   logic [mtet_pkg::ORDER_W-1:0]      age;
   logic                              due;
   logic                              precedes;
   logic                              out_free;
   logic [PW-1:0]                     rearm_step;
   logic [mtet_pkg::ID_W-1:0]         id_next;

   assign rd_addr  = scan_cnt_ff[IDXW-1:0];
   assign ent_v    = vld_ff[chk_idx_ff];
   assign da       = rd_data_ff.expiry - now_ff;
   assign late     = now_ff - rd_data_ff.expiry;
   assign age      = order_ff - rd_data_ff.order;
   assign due      = ~late[TW-1];
   assign precedes = (da != best_da_ff)
                   ? ({~da[TW-1], da[TW-2:0]} < {~best_da_ff[TW-1], best_da_ff[TW-2:0]})
                   : (age > best_age_ff);
   assign out_free   = ~rsp_vld_ff | rsp_chan.ready;
   assign rearm_step = (best_period_ff == '0) ? PW'(1) : best_period_ff;
   assign id_next    = id_ff + mtet_pkg::ID_W'(1);

   assign req_chan.ready        = (state_ff == ST_IDLE);
   assign rsp_chan.valid        = rsp_vld_ff;
   assign rsp_chan.kind         = rsp_kind_ff;
   assign rsp_chan.timer_ident  = rsp_ident_ff;
   assign rsp_chan.next_delay_ms = rsp_delay_ff;
   assign rsp_chan.last         = rsp_last_ff;

   always_comb begin
      state_in       = state_ff;
      now_in         = now_ff;
      id_in          = id_ff;
      order_in       = order_ff;
      vld_in         = vld_ff;
      scan_cnt_in    = scan_cnt_ff;
      chk_vld_in     = 1'b0;
      chk_idx_in     = rd_addr;
      found_in       = found_ff;
      any_in         = any_ff;
      fire_cnt_in    = fire_cnt_ff;
      rsp_vld_in     = rsp_vld_ff & ~rsp_chan.ready;
      cmd_in         = cmd_ff;
      timeout_in     = timeout_ff;
      rearm_in       = rearm_ff;
      cid_in         = cid_ff;
      best_idx_in    = best_idx_ff;
      best_da_in     = best_da_ff;
      best_age_in    = best_age_ff;
      best_ident_in  = best_ident_ff;
      best_period_in = best_period_ff;
      best_rearm_in  = best_rearm_ff;
      min_d_in       = min_d_ff;
      rsp_kind_in    = rsp_kind_ff;
      rsp_ident_in   = rsp_ident_ff;
      rsp_delay_in   = rsp_delay_ff;
      rsp_last_in    = rsp_last_ff;
      mem_we         = 1'b0;
      mem_wa         = best_idx_ff;
      mem_wd         = '{expiry: now_ff + TW'(timeout_ff), period: timeout_ff,
                         ident: id_next, rearm: rearm_ff, order: order_ff};

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               cmd_in     = req_chan.command;
               timeout_in = req_chan.timeout_ms;
               rearm_in   = req_chan.repeat_on_fire;
               cid_in     = req_chan.cancel_id;
               if (req_chan.command == mtet_pkg::CMD_TICK ||
                   req_chan.command == mtet_pkg::CMD_SET ||
                   req_chan.command == mtet_pkg::CMD_CANCEL) begin
                  state_in    = ST_SCAN;
                  scan_cnt_in = '0;
                  found_in    = 1'b0;
                  any_in      = 1'b0;
                  fire_cnt_in = '0;
               end
               if (req_chan.command == mtet_pkg::CMD_TICK) begin
                  now_in = now_ff + TW'(1);
               end
            end
         end
         ST_SCAN: begin
            if (scan_cnt_ff != DEPTH_CNT) begin
               chk_vld_in  = 1'b1;
               scan_cnt_in = scan_cnt_ff + CW'(1);
            end
            if (chk_vld_ff) begin
               if ((cmd_ff == mtet_pkg::CMD_SET && !ent_v && !found_ff) ||
                   (cmd_ff == mtet_pkg::CMD_CANCEL && ent_v &&
                    rd_data_ff.ident == cid_ff && (!found_ff || precedes)) ||
                   (cmd_ff == mtet_pkg::CMD_TICK && ent_v && due &&
                    (!found_ff || precedes))) begin
                  found_in       = 1'b1;
                  best_idx_in    = chk_idx_ff;
                  best_da_in     = da;
                  best_age_in    = age;
                  best_ident_in  = rd_data_ff.ident;
                  best_period_in = rd_data_ff.period;
                  best_rearm_in  = rd_data_ff.rearm;
               end
               if (ent_v) begin
                  any_in = 1'b1;
                  if (!any_ff || da < min_d_ff) begin
                     min_d_in = da;
                  end
               end
               if (chk_idx_ff == LAST_IDX) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_vld_in   = 1'b1;
               rsp_ident_in = '0;
               rsp_delay_in = '0;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
               if (cmd_ff == mtet_pkg::CMD_SET) begin
                  if (found_ff) begin
                     id_in               = id_next;
                     order_in            = order_ff + mtet_pkg::ORDER_W'(1);
                     vld_in[best_idx_ff] = 1'b1;
                     mem_we              = 1'b1;
                     rsp_kind_in         = mtet_pkg::K_SET_OK;
                     rsp_ident_in        = id_next;
                  end else begin
                     rsp_kind_in = mtet_pkg::K_SET_FULL;
                  end
               end else if (cmd_ff == mtet_pkg::CMD_CANCEL) begin
                  if (found_ff) begin
                     vld_in[best_idx_ff] = 1'b0;
                     rsp_kind_in         = mtet_pkg::K_CANCELLED;
                     rsp_ident_in        = cid_ff;
                  end else begin
                     rsp_kind_in = mtet_pkg::K_NOT_FOUND;
                  end
               end else if (found_ff && fire_cnt_ff != DEPTH_CNT) begin
                  rsp_kind_in  = mtet_pkg::K_FIRED;
                  rsp_ident_in = best_ident_ff;
                  rsp_last_in  = 1'b0;
                  fire_cnt_in  = fire_cnt_ff + CW'(1);
                  if (best_rearm_ff) begin
                     mem_we   = 1'b1;
                     mem_wd   = '{expiry: now_ff + TW'(rearm_step), period: best_period_ff,
                                  ident: best_ident_ff, rearm: 1'b1, order: order_ff};
                     order_in = order_ff + mtet_pkg::ORDER_W'(1);
                  end else begin
                     vld_in[best_idx_ff] = 1'b0;
                  end
                  state_in    = ST_SCAN;
                  scan_cnt_in = '0;
                  found_in    = 1'b0;
                  any_in      = 1'b0;
               end else begin
                  rsp_kind_in = mtet_pkg::K_TICK_DONE;
                  if (any_ff) begin
                     rsp_delay_in = (min_d_ff[TW-1:PW] != '0) ? mtet_pkg::DELAY_MAX
                                                              : min_d_ff[PW-1:0];
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         now_ff      <= '0;
         id_ff       <= '0;
         order_ff    <= '0;
         vld_ff      <= '0;
         scan_cnt_ff <= '0;
         chk_vld_ff  <= 1'b0;
         found_ff    <= 1'b0;
         any_ff      <= 1'b0;
         fire_cnt_ff <= '0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         now_ff      <= now_in;
         id_ff       <= id_in;
         order_ff    <= order_in;
         vld_ff      <= vld_in;
         scan_cnt_ff <= scan_cnt_in;
         chk_vld_ff  <= chk_vld_in;
         found_ff    <= found_in;
         any_ff      <= any_in;
         fire_cnt_ff <= fire_cnt_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_idx_ff     <= chk_idx_in;
      cmd_ff         <= cmd_in;
      timeout_ff     <= timeout_in;
      rearm_ff       <= rearm_in;
      cid_ff         <= cid_in;
      best_idx_ff    <= best_idx_in;
      best_da_ff     <= best_da_in;
      best_age_ff    <= best_age_in;
      best_ident_ff  <= best_ident_in;
      best_period_ff <= best_period_in;
      best_rearm_ff  <= best_rearm_in;
      min_d_ff       <= min_d_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_ident_ff   <= rsp_ident_in;
      rsp_delay_ff   <= rsp_delay_in;
      rsp_last_ff    <= rsp_last_in;
   end

   a_fire_bound: assert property (@(posedge clock) disable iff (reset)
      fire_cnt_ff <= DEPTH_CNT)
      else $error("fired count beyond table depth");

   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> !chk_vld_ff)
      else $error("entry write overlaps a scan read");

   a_set_free_slot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && cmd_ff == mtet_pkg::CMD_SET && found_ff)
      |-> !vld_ff[best_idx_ff])
      else $error("set targets an occupied slot");

   a_tick_done_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_kind_ff == mtet_pkg::K_TICK_DONE) |-> rsp_last_ff)
      else $error("tick done item not marked last");

   a_fired_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_kind_ff == mtet_pkg::K_FIRED) |-> !rsp_last_ff)
      else $error("fired item marked last");

endmodule

`default_nettype wire

/* tb/mtet_tb_pkg.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mtet_tb_pkg
// Timer table predictor and event scoreboard for the multi-timer expiry table
// testbench: tracks time, ids and entries, queues the events each accepted
// command causes and checks returned events against them in order.
// ----------------------------------------------------------------------------
package mtet_tb_pkg;

   import mtet_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [KIND_W-1:0]    kind;
      logic [ID_W-1:0]      timer_ident;
      logic [TIMEOUT_W-1:0] next_delay_ms;
      logic                 last;
   } timer_event_type;

   class timer_table_scoreboard;
      int                   depth;
      bit [TIME_W-1:0]      now_ms;
      bit [ID_W-1:0]        issued_id;
      bit [ORDER_W-1:0]     insert_seq;
      bit                   live[];
      bit [TIME_W-1:0]      expiry[];
      bit [TIMEOUT_W-1:0]   period[];
      bit [ID_W-1:0]        ident[];
      bit                   rearm[];
      bit [ORDER_W-1:0]     order[];
      timer_event_type      timer_events[$];
      int                   errors;

      function new(int d);
         depth      = d;
         now_ms     = '0;
         issued_id  = '0;
         insert_seq = '0;
         errors     = 0;
         live       = new[d];
         expiry     = new[d];
         period     = new[d];
         ident      = new[d];
         rearm      = new[d];
         order      = new[d];
         foreach (live[i]) live[i] = 1'b0;
      endfunction

      // earlier expiry first, then older insertion
      function bit precedes(int a, int b);
         bit [TIME_W-1:0] da, db;
         da = expiry[a] - now_ms;
         db = expiry[b] - now_ms;
         if (da != db) return $signed(da) < $signed(db);
         return (insert_seq - order[a]) > (insert_seq - order[b]);
      endfunction

      function bit is_due(int i);
         bit [TIME_W-1:0] lag;
         lag = now_ms - expiry[i];
         return lag < 32'h8000_0000;
      endfunction

      function void push_event(logic [KIND_W-1:0] kind, logic [ID_W-1:0] id,
                               logic [TIMEOUT_W-1:0] delay);
         timer_event_type ev;
         ev = '{kind, id, delay, 1'b0};
         timer_events.push_back(ev);
      endfunction

      function void apply_command(logic [CMD_W-1:0] cmd, logic [TIMEOUT_W-1:0] tmo,
                                  logic rep, logic [ID_W-1:0] cid);
         int              pick, n, slot;
         bit              any, scanning;
         bit [TIME_W-1:0] best, d;
         timer_event_type ev;
         n = 0;
         case (cmd)
            CMD_TICK: begin
               now_ms   = now_ms + 32'd1;
               scanning = 1'b1;
               while (scanning) begin
                  pick = -1;
                  for (int i = 0; i < depth; i++)
                     if (live[i] && is_due(i) && (pick < 0 || precedes(i, pick))) pick = i;
                  if (pick < 0 || n >= depth) begin
                     scanning = 1'b0;
                  end else begin
                     push_event(K_FIRED, ident[pick], '0);
                     n++;
                     if (rearm[pick]) begin
                        expiry[pick] = now_ms + ((period[pick] == 0) ? 32'd1 : 32'(period[pick]));
                        order[pick]  = insert_seq;
                        insert_seq   = insert_seq + 32'd1;
                     end else begin
                        live[pick] = 1'b0;
                     end
                  end
               end
               any  = 1'b0;
               best = '0;
               for (int i = 0; i < depth; i++) begin
                  if (live[i]) begin
                     d = expiry[i] - now_ms;
                     if (!any || d < best) best = d;
                     any = 1'b1;
                  end
               end
               if (best > 32'(DELAY_MAX)) best = 32'(DELAY_MAX);
               push_event(K_TICK_DONE, '0, any ? best[TIMEOUT_W-1:0] : '0);
            end
            CMD_SET: begin
               slot = -1;
               for (int i = depth - 1; i >= 0; i--)
                  if (!live[i]) slot = i;
               if (slot < 0) begin
                  push_event(K_SET_FULL, '0, '0);
               end else begin
                  issued_id    = issued_id + 16'd1;
                  live[slot]   = 1'b1;
                  expiry[slot] = now_ms + 32'(tmo);
                  period[slot] = tmo;
                  ident[slot]  = issued_id;
                  rearm[slot]  = rep;
                  order[slot]  = insert_seq;
                  insert_seq   = insert_seq + 32'd1;
                  push_event(K_SET_OK, issued_id, '0);
               end
            end
            CMD_CANCEL: begin
               pick = -1;
               for (int i = 0; i < depth; i++)
                  if (live[i] && ident[i] == cid && (pick < 0 || precedes(i, pick))) pick = i;
               if (pick < 0) begin
                  push_event(K_NOT_FOUND, '0, '0);
               end else begin
                  live[pick] = 1'b0;
                  push_event(K_CANCELLED, cid, '0);
               end
            end
            default: return;
         endcase
         ev      = timer_events.pop_back();
         ev.last = 1'b1;
         timer_events.push_back(ev);
      endfunction

      function void report(string field, int unsigned want, int unsigned got);
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
         errors++;
      endfunction

      function void match_event(timer_event_type got);
         timer_event_type want;
         if (timer_events.size() == 0) begin
            $display("%0t: unexpected item, expected none actual kind %0d id %0d delay %0d",
                     $time, got.kind, got.timer_ident, got.next_delay_ms);
            errors++;
            return;
         end
         want = timer_events.pop_front();
         if (got.kind !== want.kind) report("kind", want.kind, got.kind);
         if (got.timer_ident !== want.timer_ident)
            report("timer_ident", want.timer_ident, got.timer_ident);
         if (got.next_delay_ms !== want.next_delay_ms)
            report("next_delay_ms", want.next_delay_ms, got.next_delay_ms);
         if (got.last !== want.last) report("last", want.last, got.last);
      endfunction

      function int pending();
         return timer_events.size();
      endfunction

      function int live_count();
         int c;
         c = 0;
         foreach (live[i]) if (live[i]) c++;
         return c;
      endfunction

      function bit pick_live(inout logic [ID_W-1:0] id);
         int idx[$];
         foreach (live[i]) if (live[i]) idx.push_back(i);
         if (idx.size() == 0) return 1'b0;
         id = ident[idx[$urandom_range(idx.size() - 1)]];
         return 1'b1;
      endfunction
   endclass

endpackage

/* tb/tb_multi_timer_expiry_table.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_multi_timer_expiry_table
// Drives set, cancel and tick commands into the timer table under random
// sender and receiver stalls, predicts the fired, cancelled and tick events
// and checks every returned item; includes table-full, zero-period and
// same-expiry ordering sequences.
// ----------------------------------------------------------------------------
module tb_multi_timer_expiry_table;

   import mtet_pkg::*;
   import mtet_tb_pkg::*;

   localparam int DEPTH         = DEPTH_DEFAULT;
   localparam int CYCLE_LIMIT   = 12_000_000;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = (DEPTH + 2) * (DEPTH + 2) + 16;
   localparam int PHASE_ITEMS   = 100;

   logic clock;
   logic reset;
   int   send_idle_pct = 0;
   int   recv_idle_pct = 0;
   bit   hold_req      = 1'b0;
   int   cycle_count   = 0;

   timer_table_scoreboard sb;

   mtet_req_if req_chan ();
   mtet_rsp_if rsp_chan ();

   multi_timer_expiry_table #(.DEPTH(DEPTH)) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("multi_timer_expiry_table verification failed");
         $finish;
      end
   end

   initial begin
      timer_event_type got;
      int              hold_left;
      hold_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            got = '{rsp_chan.kind, rsp_chan.timer_ident, rsp_chan.next_delay_ms,
                    rsp_chan.last};
            sb.match_event(got);
         end
         if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
         end
         if (reset || hold_left > 0) begin
            if (hold_left > 0) hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [TIMEOUT_W-1:0] tmo,
                            input logic rep, input logic [ID_W-1:0] cid);
      if ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_chan.valid          <= 1'b1;
      req_chan.command        <= cmd;
      req_chan.timeout_ms     <= tmo;
      req_chan.repeat_on_fire <= rep;
      req_chan.cancel_id      <= cid;
      do @(posedge clock); while (!req_chan.ready);
      sb.apply_command(cmd, tmo, rep, cid);
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   task automatic random_item(output bit counted);
      logic [CMD_W-1:0]     cmd;
      logic [TIMEOUT_W-1:0] tmo;
      logic                 rep;
      logic [ID_W-1:0]      cid;
      int                   r;
      r   = $urandom_range(99);
      tmo = TIMEOUT_W'($urandom);
      rep = 1'($urandom_range(1));
      cid = ID_W'($urandom);
      if (r < 40) begin
         cmd = CMD_TICK;
      end else if (r < 75) begin
         cmd = CMD_SET;
         r   = $urandom_range(99);
         if (r < 70) tmo = TIMEOUT_W'($urandom_range(6));
         else if (r < 90) tmo = TIMEOUT_W'($urandom_range(40));
      end else if (r < 94) begin
         cmd = CMD_CANCEL;
         if ($urandom_range(3) != 0) void'(sb.pick_live(cid));
      end else begin
         cmd = CMD_UNUSED;
      end
      send_item(cmd, tmo, rep, cid);
      counted = (cmd != CMD_UNUSED);
   endtask

   task automatic random_phase(input int s_pct, input int r_pct, input bit with_hold);
      int done;
      bit counted;
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      done = 0;
      while (done < PHASE_ITEMS) begin
         if (with_hold && done == PHASE_ITEMS / 3) hold_req = 1'b1;
         random_item(counted);
         if (counted) done++;
      end
      wait_drained();
   endtask

   initial begin
      logic [ID_W-1:0] id;
      sb = new(DEPTH);
      reset                   <= 1'b1;
      req_chan.valid          <= 1'b0;
      req_chan.command        <= CMD_TICK;
      req_chan.timeout_ms     <= '0;
      req_chan.repeat_on_fire <= 1'b0;
      req_chan.cancel_id      <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: ignored code, misses, zero period, max delay, same-expiry order, full
      send_item(CMD_UNUSED, DELAY_MAX, 1'b1, '1);
      send_item(CMD_CANCEL, '0, 1'b0, '0);
      send_item(CMD_TICK, '0, 1'b0, '0);
      send_item(CMD_SET, '0, 1'b1, '0);
      id = sb.issued_id;
      send_item(CMD_TICK, '0, 1'b0, '0);
      send_item(CMD_TICK, '1, 1'b1, '1);
      send_item(CMD_SET, DELAY_MAX, 1'b0, '1);
      send_item(CMD_SET, 24'd2, 1'b0, '0);
      send_item(CMD_SET, 24'd2, 1'b1, '0);
      repeat (3) send_item(CMD_TICK, '0, 1'b0, '0);
      send_item(CMD_CANCEL, '0, 1'b0, id);
      repeat (DEPTH - 1) send_item(CMD_SET, 24'd100, 1'b0, '0);
      send_item(CMD_CANCEL, '0, 1'b0, sb.issued_id);
      wait_drained();

      random_phase(32, 72, 1'b1);
      random_phase(72, 32, 1'b0);
      random_phase(0, 0, 1'b0);

      req_chan.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("multi_timer_expiry_table verification clean");
      else
         $display("multi_timer_expiry_table verification failed");
      $finish;
   end

endmodule
